>>> rtl/cpts_pkg.sv
// ----------------------------------------------------------------------------
// Counter/priority task scheduler package
// Command codes, per-slot operation codes and the command bundle that the
// controller broadcasts to the slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cpts_pkg;

   // Transaction command codes on req_command.
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_CREATE  = 2'd1;
   localparam logic [1:0] CMD_SET_RUN = 2'd2;

   // Stack allocator value after reset.
   localparam logic [15:0] STACK_BASE_RESET = 16'd4351;

   // Operation applied by the selected cells (or by every used slot but the idle one, for a recharge).
   typedef enum logic [2:0] {
      OP_IDLE     = 3'd0,
      OP_DECR     = 3'd1,
      OP_LOAD     = 3'd2,
      OP_SET_RUN  = 3'd3,
      OP_RECHARGE = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        flag;
      logic [7:0]  prio;
   } cell_cmd_type;

endpackage : cpts_pkg

`default_nettype wire

>>> rtl/counter_priority_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Counter/priority task scheduler
// Task-slot scheduler with timer tick, task creation and run-flag commands.
// ----------------------------------------------------------------------------
// Sequence: set-runnable or unknown command goes EXEC, DONE; tick goes EXEC, CHECK,
// then SCAN on a reschedule, with a second SCAN when the used counters are recharged,
// and DONE; create goes EXEC, SCAN, DONE. Cell chain settling sets the scan length.
// Throughput: one transaction at a time; start is taken again right after the strobe.
// Reset is synchronous: slot 0 (idle) is the only used task and runs.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_priority_task_scheduler_unit
   import cpts_pkg::*;
#(
   parameter int TASK_SLOTS   = 8,
   parameter int COUNTER_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Command channel.
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [2:0]  req_task_slot,
   input  wire logic        req_runnable,
   input  wire logic [7:0]  req_task_priority,
   input  wire logic [15:0] req_stack_size,
   // Result channel.
   output      logic        rsp_valid,
   output      logic [2:0]  rsp_current_task,
   output      logic        rsp_rescheduled,
   output      logic        rsp_create_ok,
   output      logic [2:0]  rsp_created_slot,
   output      logic [15:0] rsp_stack_top,
   // Configuration: stack_base register.
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   localparam int SLOT_W  = $clog2(TASK_SLOTS);
   localparam int SCAN_W  = $clog2(TASK_SLOTS + 1);
   localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(TASK_SLOTS);

   // One-hot controller states.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EXEC  = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Transaction captured at acceptance.
   logic [1:0]  command_ff;
   logic [2:0]  slot_ff;
   logic        runnable_ff;
   logic [7:0]  prio_ff;
   logic [15:0] size_ff;

   // Scheduler state outside the cells.
   logic [SLOT_W-1:0] running_ff, running_in;
   logic [15:0]       next_top_ff, next_top_in;
   logic [SCAN_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic              pass_ff, pass_in;

   // Result registers.
   logic              resched_ff, resched_in;
   logic              ok_ff, ok_in;
   logic [2:0]        cslot_ff, cslot_in;
   logic [15:0]       top_ff, top_in;

   // Cell chain. Stage 0 feeds the idle cell with an empty candidate; the
   // last stage carries the settled scan result.
   cell_cmd_type            cell_cmd;
   logic [TASK_SLOTS-1:0]   sel_vec;
   logic [TASK_SLOTS-1:0]   zero_vec;
   logic                    best_found [TASK_SLOTS+1];
   logic [COUNTER_BITS-1:0] best_cnt   [TASK_SLOTS+1];
   logic [SLOT_W-1:0]       best_idx   [TASK_SLOTS+1];
   logic                    free_found [TASK_SLOTS+1];
   logic [SLOT_W-1:0]       free_idx   [TASK_SLOTS+1];

   logic                    accept;
   logic                    use_slot_port;
   logic [SLOT_W-1:0]       target;

   assign accept        = start && state_ff[0];
   assign best_found[0] = 1'b0;
   assign best_cnt[0]   = '0;
   assign best_idx[0]   = '0;
   assign free_found[0] = 1'b0;
   assign free_idx[0]   = '0;

   for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
      cpts_cell #(
         .COUNTER_BITS (COUNTER_BITS),
         .SLOT_W       (SLOT_W),
         .INDEX        (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cell_cmd),
         .sel          (sel_vec[g]),
         .best_found_i (best_found[g]),
         .best_cnt_i   (best_cnt[g]),
         .best_idx_i   (best_idx[g]),
         .free_found_i (free_found[g]),
         .free_idx_i   (free_idx[g]),
         .best_found_o (best_found[g+1]),
         .best_cnt_o   (best_cnt[g+1]),
         .best_idx_o   (best_idx[g+1]),
         .free_found_o (free_found[g+1]),
         .free_idx_o   (free_idx[g+1]),
         .cnt_zero     (zero_vec[g])
      );
   end

   // Slot select. A set-runnable addresses the slot from the request; a
   // slot number at or beyond TASK_SLOTS matches no cell and is ignored.
   always_comb begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (use_slot_port) begin
            sel_vec[i] = (32'(slot_ff) == 32'(i));
         end else begin
            sel_vec[i] = (target == SLOT_W'(i));
         end
      end
   end

   // Controller. The chain runs every cycle; in ST_SCAN the controller counts scan_cnt
   // up to SCAN_LAST so the last stage has settled before the scan result is used.
   always_comb begin
      state_in      = state_ff;
      running_in    = running_ff;
      next_top_in   = next_top_ff;
      scan_cnt_in   = scan_cnt_ff;
      pass_in       = pass_ff;
      resched_in    = resched_ff;
      ok_in         = ok_ff;
      cslot_in      = cslot_ff;
      top_in        = top_ff;
      cell_cmd.op   = OP_IDLE;
      cell_cmd.flag = runnable_ff;
      cell_cmd.prio = prio_ff;
      use_slot_port = 1'b0;
      target        = running_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               resched_in = 1'b0;
               ok_in      = 1'b0;
               cslot_in   = 3'd0;
               top_in     = 16'd0;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            scan_cnt_in = '0;
            pass_in     = 1'b0;
            case (command_ff)
               CMD_TICK: begin
                  cell_cmd.op = OP_DECR;
                  state_in    = ST_CHECK;
               end
               CMD_CREATE: begin
                  state_in = ST_SCAN;
               end
               CMD_SET_RUN: begin
                  cell_cmd.op   = OP_SET_RUN;
                  use_slot_port = 1'b1;
                  state_in      = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_CHECK: begin
            // The running counter has just been decremented.
            if (zero_vec[running_ff]) begin
               resched_in = 1'b1;
               state_in   = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + SCAN_W'(1);
            if (scan_cnt_ff == SCAN_LAST) begin
               if (command_ff == CMD_CREATE) begin
                  if (free_found[TASK_SLOTS]) begin
                     cell_cmd.op = OP_LOAD;
                     target      = free_idx[TASK_SLOTS];
                     ok_in       = 1'b1;
                     cslot_in    = 3'(free_idx[TASK_SLOTS]);
                     top_in      = next_top_ff;
                     next_top_in = next_top_ff - size_ff;
                  end
                  state_in = ST_DONE;
               end else if (best_found[TASK_SLOTS] && (best_cnt[TASK_SLOTS] == '0)
                            && !pass_ff) begin
                  // Every candidate is used up: recharge all used slots and
                  // scan a second time.
                  cell_cmd.op = OP_RECHARGE;
                  pass_in     = 1'b1;
                  scan_cnt_in = '0;
               end else begin
                  running_in = best_found[TASK_SLOTS] ? best_idx[TASK_SLOTS] : '0;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Writing stack_base restarts the stack allocator.
      if (csr_wr_en) begin
         next_top_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         running_ff  <= '0;
         next_top_ff <= STACK_BASE_RESET;
         scan_cnt_ff <= '0;
         pass_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         running_ff  <= running_in;
         next_top_ff <= next_top_in;
         scan_cnt_ff <= scan_cnt_in;
         pass_ff     <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         command_ff  <= req_command;
         slot_ff     <= req_task_slot;
         runnable_ff <= req_runnable;
         prio_ff     <= req_task_priority;
         size_ff     <= req_stack_size;
      end
      resched_ff <= resched_in;
      ok_ff      <= ok_in;
      cslot_ff   <= cslot_in;
      top_ff     <= top_in;
   end

   assign busy             = !state_ff[0];
   assign rsp_valid        = state_ff[4];
   assign rsp_current_task = 3'(running_ff);
   assign rsp_rescheduled  = resched_ff;
   assign rsp_create_ok    = ok_ff;
   assign rsp_created_slot = cslot_ff;
   assign rsp_stack_top    = top_ff;

endmodule : counter_priority_task_scheduler_unit

`default_nettype wire

>>> rtl/cpts_cell.sv
// ----------------------------------------------------------------------------
// Scheduler slot cell
// Holds one task slot and forwards the running best candidate and the first
// free slot to its neighbor through registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_cell
   import cpts_pkg::*;
#(
   parameter int COUNTER_BITS = 16,
   parameter int SLOT_W       = 3,
   parameter int INDEX        = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cell_cmd_type            cmd,
   input  wire logic                    sel,
   input  wire logic                    best_found_i,
   input  wire logic [COUNTER_BITS-1:0] best_cnt_i,
   input  wire logic [SLOT_W-1:0]       best_idx_i,
   input  wire logic                    free_found_i,
   input  wire logic [SLOT_W-1:0]       free_idx_i,
   output      logic                    best_found_o,
   output      logic [COUNTER_BITS-1:0] best_cnt_o,
   output      logic [SLOT_W-1:0]       best_idx_o,
   output      logic                    free_found_o,
   output      logic [SLOT_W-1:0]       free_idx_o,
   output      logic                    cnt_zero
);

   // The idle slot never takes part in the scan, recharge or allocation.
   localparam logic              MEMBER   = (INDEX != 0);
   localparam logic [SLOT_W-1:0] MY_INDEX = SLOT_W'(INDEX);

   logic                    used_ff, used_in;
   logic                    run_ff, run_in;
   logic [COUNTER_BITS-1:0] cnt_ff, cnt_in;
   logic [7:0]              prio_ff, prio_in;
   logic                    best_found_ff, best_found_in;
   logic [COUNTER_BITS-1:0] best_cnt_ff, best_cnt_in;
   logic [SLOT_W-1:0]       best_idx_ff, best_idx_in;
   logic                    free_found_ff, free_found_in;
   logic [SLOT_W-1:0]       free_idx_ff, free_idx_in;
   logic                    qual;

   always_comb begin
      used_in = used_ff;
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      prio_in = prio_ff;
      case (cmd.op)
         OP_DECR: begin
            if (sel) begin
               cnt_in = cnt_ff - COUNTER_BITS'(1);
            end
         end
         OP_LOAD: begin
            if (sel) begin
               used_in = 1'b1;
               run_in  = 1'b1;
               cnt_in  = COUNTER_BITS'(cmd.prio);
               prio_in = cmd.prio;
            end
         end
         OP_SET_RUN: begin
            if (sel) begin
               run_in = cmd.flag;
            end
         end
         OP_RECHARGE: begin
            if (MEMBER && used_ff) begin
               cnt_in = (cnt_ff >> 1) + COUNTER_BITS'(prio_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // A slot qualifies when used, runnable and its counter is non-negative.
   // Ties go to the later (higher) slot.
   always_comb begin
      qual = MEMBER && used_ff && run_ff && !cnt_ff[COUNTER_BITS-1];
      if (qual && (!best_found_i || (cnt_ff >= best_cnt_i))) begin
         best_found_in = 1'b1;
         best_cnt_in   = cnt_ff;
         best_idx_in   = MY_INDEX;
      end else begin
         best_found_in = best_found_i;
         best_cnt_in   = best_cnt_i;
         best_idx_in   = best_idx_i;
      end
      if (free_found_i) begin
         free_found_in = 1'b1;
         free_idx_in   = free_idx_i;
      end else begin
         free_found_in = MEMBER && !used_ff;
         free_idx_in   = MY_INDEX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= !MEMBER;
         run_ff        <= !MEMBER;
         cnt_ff        <= MEMBER ? '0 : COUNTER_BITS'(1);
         prio_ff       <= MEMBER ? 8'd0 : 8'd1;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         used_ff       <= used_in;
         run_ff        <= run_in;
         cnt_ff        <= cnt_in;
         prio_ff       <= prio_in;
         best_found_ff <= best_found_in;
         free_found_ff <= free_found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_cnt_ff <= best_cnt_in;
      best_idx_ff <= best_idx_in;
      free_idx_ff <= free_idx_in;
   end

   assign best_found_o = best_found_ff;
   assign best_cnt_o   = best_cnt_ff;
   assign best_idx_o   = best_idx_ff;
   assign free_found_o = free_found_ff;
   assign free_idx_o   = free_idx_ff;
   assign cnt_zero     = (cnt_ff == '0);

endmodule : cpts_cell

`default_nettype wire

>>> rtl/cpts_checker.sv
// ----------------------------------------------------------------------------
// Counter/priority task scheduler checker
// Port-level assertions on the command and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_rescheduled,
   input wire logic        rsp_create_ok,
   input wire logic [2:0]  rsp_created_slot,
   input wire logic [15:0] rsp_stack_top
);

   // An accepted transaction keeps the block busy in the next cycle.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // A result belongs to a transaction still in flight and lasts one cycle.
   a_strobe_pulse : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 !rsp_valid)
      else $error("result strobe outside a transaction or longer than one cycle");

   // A failed or non-create transaction reports no slot and no stack top.
   a_no_create : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_create_ok |-> rsp_created_slot == 3'd0 && rsp_stack_top == 16'd0)
      else $error("create fields set without a successful create");

   // A create never lands in the idle slot and never reschedules.
   a_create_slot : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_create_ok |-> rsp_created_slot != 3'd0 && !rsp_rescheduled)
      else $error("create result inconsistent");

endmodule : cpts_checker

bind counter_priority_task_scheduler_unit cpts_checker u_cpts_checker (.*);

`default_nettype wire
